>>> rtl/core/etpf_pkg.sv
`timescale 1ns / 1ps
package etpf_pkg;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(60);
    localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam logic [1:0] FCS_LAST_IDX = 2'd3;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END_RAW = 2'd1,
        KIND_END_FCS = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
    } t_qent;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (v[0] ? FCS_POLY : 32'd0);
        end
        return v;
    endfunction

endpackage

>>> rtl/core/ethernet_tx_pad_and_fcs.sv
`timescale 1ns / 1ps
// Transmit pad and FCS stage. Frame bytes enter one word per cycle on the
// slave side while the queue is not full and leave unchanged on the master
// side; after a last word with tuser clear, zero pad words follow until the
// frame holds 60 bytes, then the four FCS bytes (inverted reflected CRC-32,
// least significant first), the final one marked with tlast. With tuser set
// on the last word, that word ends the frame and carries tlast. Pad and FCS
// words hold the output port while no new data word is taken there, and a
// four-word queue keeps the input taking words meanwhile until it fills.
// Each input word passes through the queue memory and then the output
// register before it is presented.
module ethernet_tx_pad_and_fcs (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,
    input  logic       i_s_tuser,   // [0] no_crc
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);
    import etpf_pkg::*;

    logic  q_valid;
    t_qent q_ent;
    logic  q_pop;

    etpf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_data    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_no_crc  (i_s_tuser),
        .o_q_valid (q_valid),
        .o_q_ent   (q_ent),
        .i_q_pop   (q_pop)
    );

    etpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule

>>> rtl/core/etpf_front.sv
`timescale 1ns / 1ps
module etpf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data,
    input  logic                 i_last,
    input  logic                 i_no_crc,
    output logic                 o_q_valid,
    output etpf_pkg::t_qent      o_q_ent,
    input  logic                 i_q_pop
);
    import etpf_pkg::*;

    t_qent            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_AW:0]    r_count;
    logic             push;
    logic             pop;
    t_qent            ent;

    assign o_ready   = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_ent   = r_mem[r_rptr];

    always_comb begin
        ent.data = i_data;
        if (!i_last) begin
            ent.kind = KIND_DATA;
        end else if (i_no_crc) begin
            ent.kind = KIND_END_RAW;
        end else begin
            ent.kind = KIND_END_FCS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (push) begin
            r_mem[r_wptr] <= ent;
        end
    end

endmodule

>>> rtl/core/etpf_back.sv
`timescale 1ns / 1ps
module etpf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  etpf_pkg::t_qent      i_q_ent,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_data,
    output logic                 o_last
);
    import etpf_pkg::*;

    typedef enum logic [1:0] {
        ST_PASS,
        ST_PAD,
        ST_FCS
    } t_state;

    t_state           r_state, n_state;
    logic [31:0]      r_crc, n_crc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_fidx, n_fidx;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_obyte, n_obyte;
    logic             r_olast, n_olast;
    logic             adv;
    logic [7:0]       in_byte;
    logic [31:0]      crc_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic [31:0]      fcs;

    assign adv     = !r_ovalid || i_ready;
    assign in_byte = (r_state == ST_PAD) ? 8'd0 : i_q_ent.data;
    assign crc_upd = crc_byte(r_crc, in_byte);
    assign cnt_upd = (r_cnt < MIN_LEN) ? r_cnt + 1'b1 : r_cnt;
    assign fcs     = ~r_crc;

    assign o_valid = r_ovalid;
    assign o_data  = r_obyte;
    assign o_last  = r_olast;

    always_comb begin
        n_state  = r_state;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_fidx   = r_fidx;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        o_q_pop  = 1'b0;
        if (adv) begin
            n_ovalid = 1'b0;
            case (r_state)
                ST_PASS: begin
                    if (i_q_valid) begin
                        o_q_pop  = 1'b1;
                        n_ovalid = 1'b1;
                        n_obyte  = i_q_ent.data;
                        n_olast  = 1'b0;
                        n_crc    = crc_upd;
                        n_cnt    = cnt_upd;
                        case (i_q_ent.kind)
                            KIND_END_RAW: begin
                                n_olast = 1'b1;
                                n_crc   = CRC_INIT;
                                n_cnt   = '0;
                            end
                            KIND_END_FCS: begin
                                n_fidx  = '0;
                                n_state = (cnt_upd < MIN_LEN) ? ST_PAD : ST_FCS;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_PAD: begin
                    n_ovalid = 1'b1;
                    n_obyte  = 8'd0;
                    n_olast  = 1'b0;
                    n_crc    = crc_upd;
                    n_cnt    = cnt_upd;
                    if (cnt_upd >= MIN_LEN) begin
                        n_state = ST_FCS;
                    end
                end
                ST_FCS: begin
                    n_ovalid = 1'b1;
                    n_obyte  = fcs[8*r_fidx +: 8];
                    n_olast  = (r_fidx == FCS_LAST_IDX);
                    n_fidx   = r_fidx + 1'b1;
                    if (r_fidx == FCS_LAST_IDX) begin
                        n_state = ST_PASS;
                        n_crc   = CRC_INIT;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_state = ST_PASS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_PASS;
            r_crc    <= CRC_INIT;
            r_cnt    <= '0;
            r_fidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
            r_fidx   <= n_fidx;
            r_ovalid <= n_ovalid;
        end
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import etpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 16;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_wire_word;

    class fcs_scoreboard;
        logic [31:0]      crc;
        logic [CNT_W-1:0] count;
        t_wire_word       wire_q[$];

        function new();
            restart();
        endfunction

        function void restart();
            crc = CRC_INIT;
            count = '0;
        endfunction

        function void fold(logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = crc[0] ^ b[i];
                crc = {1'b0, crc[31:1]};
                if (fb) crc = crc ^ FCS_POLY;
            end
            if (count < MIN_LEN) count = count + 1'b1;
        endfunction

        function void push(logic [7:0] b, logic last);
            t_wire_word w;
            w.value = b;
            w.last = last;
            wire_q.push_back(w);
        endfunction

        function void note_byte(logic [7:0] b, logic last, logic no_fcs);
            logic [31:0] fcs;
            fold(b);
            if (!last) begin
                push(b, 1'b0);
            end else if (no_fcs) begin
                push(b, 1'b1);
                restart();
            end else begin
                push(b, 1'b0);
                while (count < MIN_LEN) begin
                    fold(8'h00);
                    push(8'h00, 1'b0);
                end
                fcs = ~crc;
                for (int k = 0; k < 4; k++) push(fcs[8*k +: 8], k == 3);
                restart();
            end
        endfunction

        function string check_word(logic [7:0] b, logic last);
            t_wire_word w;
            string msg;
            msg = "";
            if (wire_q.size() == 0) begin
                return $sformatf("unexpected word byte=%02h last=%0b", b, last);
            end
            w = wire_q.pop_front();
            if (b !== w.value)
                msg = $sformatf("byte got %02h want %02h", b, w.value);
            if (last !== w.last)
                msg = {msg, $sformatf(" last got %0b want %0b", last, w.last)};
            return msg;
        endfunction

        function int pending();
            return wire_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] data_byte
    logic       i_s_tlast;
    logic       i_s_tuser;   // [0] no_crc
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] out_byte
    logic       o_m_tlast;

    fcs_scoreboard sb;
    int errors;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_cycles;

    ethernet_tx_pad_and_fcs uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic send_byte(logic [7:0] b, logic last, logic no_fcs);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        i_s_tuser  <= no_fcs;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic send_frame(int len, logic no_fcs, logic noise);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            send_byte(8'($urandom_range(255)), last,
                      last ? no_fcs : (noise & 1'($urandom_range(1))));
        end
    endtask

    task automatic send_random_frame();
        int sel;
        int len;
        sel = $urandom_range(9);
        if (sel < 4)      len = $urandom_range(12, 1);
        else if (sel < 7) len = $urandom_range(64, 55);
        else if (sel < 9) len = $urandom_range(54, 13);
        else              len = $urandom_range(90, 65);
        send_frame(len, $urandom_range(3) == 0, 1'($urandom_range(1)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_byte(i_s_tdata, i_s_tlast, i_s_tuser);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            msg = sb.check_word(o_m_tdata, o_m_tlast);
            if (msg != "") report(msg);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        errors = 0;
        items_sent = 0;
        tx_idle_pct = 33;
        rx_idle_pct = 58;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = 8'h00;
        i_s_tlast = 1'b0;
        i_s_tuser = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // shortest frames: full padding, and raw single byte
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        // no_crc on middle bytes is ignored
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b1, 1'b1);
        // 59, 60 and 61 byte frames are below, at and past the minimum
        send_frame(59, 1'b0, 1'b0);
        send_frame(60, 1'b0, 1'b1);
        send_frame(61, 1'b0, 1'b0);
        send_frame(3, 1'b1, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int target = items_sent + PHASE_ITEMS; items_sent < target; )
                send_random_frame();
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) report($sformatf("%0d words never arrived", sb.pending()));

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/etpf_pkg.sv
rtl/core/etpf_front.sv
rtl/core/etpf_back.sv
rtl/core/ethernet_tx_pad_and_fcs.sv
bench/tb_top.sv
